>>> rtl/core/button_event_detector_unit_macros.svh
// Assertion macros for the button event detector
`ifndef BUTTON_EVENT_DETECTOR_UNIT_MACROS_SVH
`define BUTTON_EVENT_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BED_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BED_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bed_pkg.sv
// Shared types, constants and helpers for the button event detector
package bed_pkg;

    localparam int TIMER_BITS = 16;
    localparam int TAP_W      = 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic [TAP_W-1:0] MAX_TAPS = TAP_W'(15);

    localparam int T_PUSH = 0;
    localparam int T_REL  = 1;
    localparam int T_WIN  = 2;
    localparam int T_REP  = 3;
    localparam int T_H0   = 4;
    localparam int T_H1   = 5;
    localparam int NTIM   = 6;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_WINDOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_LIMIT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_START    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_NOW        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DEFERRED   = 3'd7;

    localparam logic [TIMER_BITS-1:0] DEBOUNCE_RST        = TIMER_BITS'(50);
    localparam logic [TIMER_BITS-1:0] TAP_WINDOW_RST      = TIMER_BITS'(300);
    localparam logic [TIMER_BITS-1:0] REPEAT_INTERVAL_RST = TIMER_BITS'(1000);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_PUSHED = 2'd1,
        MODE_HELD   = 2'd2
    } t_mode;

    typedef struct packed {
        logic                  active_high;
        logic [TIMER_BITS-1:0] debounce_ticks;
        logic [TIMER_BITS-1:0] tap_window_ticks;
        logic [TAP_W-1:0]      tap_limit;
        logic [TIMER_BITS-1:0] repeat_start_ticks;
        logic [TIMER_BITS-1:0] repeat_interval_ticks;
        logic [TIMER_BITS-1:0] hold_now_ticks;
        logic [TIMER_BITS-1:0] hold_deferred_ticks;
    } t_cfg;

    typedef struct packed {
        logic                  start;
        logic                  stop;
        logic [TIMER_BITS-1:0] period;
    } t_tmr_cmd;

    typedef struct packed {
        logic             push_event;
        logic             hold_event;
        logic             hold_release_event;
        logic             count_event;
        logic [TAP_W-1:0] reported_taps;
        logic             short_tap_event;
        logic             release_event;
        logic             repeat_event;
        t_mode            pressed_mode;
    } t_result;

    function automatic logic [TIMER_BITS-1:0] clamp_period(input logic [TIMER_BITS-1:0] v);
        return (v == '0) ? TIMER_BITS'(1) : v;
    endfunction

endpackage

>>> rtl/core/button_event_detector_unit.sv
// Top level of the button event detector: config registers, input and result stages
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ------------------------------------
//  tick in   input      i_valid / o_ready    i_pin_level
//  events    output     o_valid / i_ready    o_push_event .. o_pressed_mode
//  config    input      i_cfg_wr_en          i_cfg_index, i_cfg_data
//
// One tick per clock cycle unless the output stalls. An accepted tick is held in the tick
// register, then passes through the timer bank and handlers into the result register,
// where its events appear on the output.
// Synchronous active-low reset; no clearing pass.
// A stalled result holds; the tick register keeps its tick and takes no new one while the result waits.
`include "button_event_detector_unit_macros.svh"

module button_event_detector_unit import bed_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_pin_level,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_push_event,
    output logic                  o_hold_event,
    output logic                  o_hold_release_event,
    output logic                  o_count_event,
    output logic [TAP_W-1:0]      o_reported_taps,
    output logic                  o_short_tap_event,
    output logic                  o_release_event,
    output logic                  o_repeat_event,
    output logic [1:0]            o_pressed_mode,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [TIMER_BITS-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    logic    r_pin;
    logic    r_out_valid;
    t_result r_out;
    t_result res;
    logic    adv;

    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_high           <= 1'b0;
            r_cfg.debounce_ticks        <= DEBOUNCE_RST;
            r_cfg.tap_window_ticks      <= TAP_WINDOW_RST;
            r_cfg.tap_limit             <= '0;
            r_cfg.repeat_start_ticks    <= '0;
            r_cfg.repeat_interval_ticks <= REPEAT_INTERVAL_RST;
            r_cfg.hold_now_ticks        <= '0;
            r_cfg.hold_deferred_ticks   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_ACTIVE_HIGH:     r_cfg.active_high           <= i_cfg_data[0];
                REG_DEBOUNCE:        r_cfg.debounce_ticks        <= i_cfg_data;
                REG_TAP_WINDOW:      r_cfg.tap_window_ticks      <= i_cfg_data;
                REG_TAP_LIMIT:       r_cfg.tap_limit             <= i_cfg_data[TAP_W-1:0];
                REG_REPEAT_START:    r_cfg.repeat_start_ticks    <= i_cfg_data;
                REG_REPEAT_INTERVAL: r_cfg.repeat_interval_ticks <= i_cfg_data;
                REG_HOLD_NOW:        r_cfg.hold_now_ticks        <= i_cfg_data;
                REG_HOLD_DEFERRED:   r_cfg.hold_deferred_ticks   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // hold the tick until the result stage can take its events
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_pin <= i_pin_level;
        end
    end

    bed_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_pin   (r_pin),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_push_event         = r_out.push_event;
    assign o_hold_event         = r_out.hold_event;
    assign o_hold_release_event = r_out.hold_release_event;
    assign o_count_event        = r_out.count_event;
    assign o_reported_taps      = r_out.reported_taps;
    assign o_short_tap_event    = r_out.short_tap_event;
    assign o_release_event      = r_out.release_event;
    assign o_repeat_event       = r_out.repeat_event;
    assign o_pressed_mode       = r_out.pressed_mode;

    `BED_ASSERT_IMP(a_taps_zero, r_out_valid && !r_out.count_event, r_out.reported_taps == '0, "reported taps without count event")
    `BED_ASSERT_IMP(a_taps_nonzero, r_out_valid && r_out.count_event, r_out.reported_taps != '0, "count event with zero taps")
    `BED_ASSERT_IMP(a_release_idle, r_out_valid && r_out.release_event, r_out.pressed_mode == MODE_IDLE, "release leaves mode not idle")
    `BED_ASSERT_IMP(a_short_release, r_out_valid && r_out.short_tap_event, r_out.release_event, "short tap without release")
    `BED_ASSERT_NXT(a_tick_held, r_in_valid && r_out_valid && !i_ready, r_in_valid, "stalled tick dropped")

endmodule

>>> rtl/core/bed_timer.sv
// One countdown timer: early start or stop, a countdown step per tick, late start or stop
module bed_timer import bed_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  t_tmr_cmd i_pre,
    input  t_tmr_cmd i_post,
    output logic     o_expire,
    output logic     o_run_after
);

    logic                  r_run;
    logic [TIMER_BITS-1:0] r_cnt;
    logic                  n_run;
    logic [TIMER_BITS-1:0] n_cnt;
    logic                  run_p;
    logic [TIMER_BITS-1:0] cnt_p;
    logic                  run_c;
    logic [TIMER_BITS-1:0] cnt_c;

    always_comb begin
        run_p = r_run;
        cnt_p = r_cnt;
        if (i_pre.start) begin
            run_p = 1'b1;
            cnt_p = clamp_period(i_pre.period);
        end else if (i_pre.stop) begin
            run_p = 1'b0;
            cnt_p = '0;
        end

        run_c    = run_p;
        cnt_c    = cnt_p;
        o_expire = 1'b0;
        if (!i_pre.start && run_p) begin
            cnt_c = (cnt_p == '0) ? '0 : cnt_p - TIMER_BITS'(1);
            if (cnt_c == '0) begin
                run_c    = 1'b0;
                o_expire = 1'b1;
            end
        end
        o_run_after = run_c;

        n_run = run_c;
        n_cnt = cnt_c;
        if (i_post.start) begin
            n_run = 1'b1;
            n_cnt = clamp_period(i_post.period);
        end else if (i_post.stop) begin
            n_run = 1'b0;
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_adv) begin
            r_run <= n_run;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> rtl/core/bed_core.sv
// Button state, timer bank and per-tick event handlers
module bed_core import bed_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  logic    i_pin,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    logic             r_last;
    t_mode            r_mode;
    logic             r_hold_pending;
    logic [TAP_W-1:0] r_taps;
    t_mode            n_mode;
    logic             n_hold_pending;
    logic [TAP_W-1:0] n_taps;

    t_tmr_cmd         pre  [NTIM];
    t_tmr_cmd         post [NTIM];
    logic [NTIM-1:0]  tmr_exp;
    logic [NTIM-1:0]  tmr_run;

    logic             pressed;
    logic             edge_on;
    logic             edge_off;
    logic             push_ok;
    logic             rel_hit;
    logic             win_hit;
    logic             rep_hit;
    logic             h0_hit;
    logic             h1_hit;
    logic             rep_on;
    logic             ev_cnt;
    logic             ev_hrel;
    logic [TAP_W-1:0] taps_out;

    for (genvar gi = 0; gi < NTIM; gi++) begin : g_tmr
        bed_timer u_tmr (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_adv       (i_adv),
            .i_pre       (pre[gi]),
            .i_post      (post[gi]),
            .o_expire    (tmr_exp[gi]),
            .o_run_after (tmr_run[gi])
        );
    end

    assign pressed  = (i_pin == i_cfg.active_high);
    assign edge_on  = (i_pin != r_last) && pressed;
    assign edge_off = (i_pin != r_last) && !pressed;
    assign rep_on   = (i_cfg.repeat_start_ticks != '0);

    assign push_ok = tmr_exp[T_PUSH] && pressed;
    assign rel_hit = tmr_exp[T_REL] && !tmr_exp[T_PUSH] && !pressed;
    assign win_hit = tmr_exp[T_WIN] && !push_ok;
    assign rep_hit = tmr_exp[T_REP] && !push_ok && !rel_hit;
    assign h0_hit  = tmr_exp[T_H0] && pressed;
    assign h1_hit  = tmr_exp[T_H1] && pressed;

    always_comb begin
        pre[T_PUSH]  = '{start: edge_on, stop: 1'b0, period: i_cfg.debounce_ticks};
        pre[T_REL]   = '{start: edge_off, stop: 1'b0, period: i_cfg.debounce_ticks};
        pre[T_WIN]   = '{start: 1'b0, stop: 1'b0, period: '0};
        pre[T_REP]   = '{start: 1'b0, stop: 1'b0, period: '0};
        pre[T_H0]    = '{start:  edge_on && (i_cfg.hold_now_ticks != '0),
                         stop:   edge_on && (i_cfg.hold_now_ticks == '0),
                         period: i_cfg.hold_now_ticks};
        pre[T_H1]    = '{start:  edge_on && (i_cfg.hold_deferred_ticks != '0),
                         stop:   edge_on && (i_cfg.hold_deferred_ticks == '0),
                         period: i_cfg.hold_deferred_ticks};

        post[T_PUSH] = '{start: 1'b0, stop: 1'b0, period: '0};
        post[T_REL]  = '{start:  tmr_exp[T_PUSH] && !pressed,
                         stop:   push_ok,
                         period: i_cfg.debounce_ticks};
        post[T_WIN]  = '{start: push_ok, stop: 1'b0, period: i_cfg.tap_window_ticks};
        post[T_REP]  = '{start:  (push_ok && rep_on) || rep_hit,
                         stop:   (push_ok && !rep_on) || rel_hit,
                         period: rep_hit ? i_cfg.repeat_interval_ticks
                                         : i_cfg.repeat_start_ticks};
        post[T_H0]   = '{start: 1'b0, stop: rel_hit, period: '0};
        post[T_H1]   = '{start: 1'b0, stop: rel_hit, period: '0};
    end

    always_comb begin
        n_mode         = r_mode;
        n_taps         = r_taps;
        n_hold_pending = r_hold_pending;
        ev_cnt         = 1'b0;
        ev_hrel        = 1'b0;
        taps_out       = '0;

        if (push_ok) begin
            n_mode = MODE_PUSHED;
            if (r_taps < MAX_TAPS) begin
                n_taps = r_taps + TAP_W'(1);
            end
        end

        if (win_hit) begin
            if (i_cfg.tap_limit != '0 && r_taps != '0 && r_taps <= i_cfg.tap_limit &&
                r_mode == MODE_IDLE) begin
                ev_cnt   = 1'b1;
                taps_out = r_taps;
            end
            n_taps = '0;
        end

        if (rel_hit) begin
            if (r_hold_pending && r_mode != MODE_IDLE) begin
                ev_hrel        = 1'b1;
                n_hold_pending = 1'b0;
            end else if (r_mode == MODE_PUSHED && !tmr_run[T_WIN] &&
                         i_cfg.tap_limit != '0) begin
                ev_cnt   = 1'b1;
                taps_out = TAP_W'(1);
            end
            n_mode = MODE_IDLE;
        end

        if (h0_hit || h1_hit) begin
            n_mode = MODE_HELD;
        end
        if (h1_hit) begin
            n_hold_pending = 1'b1;
        end

        o_res.push_event         = push_ok;
        o_res.hold_event         = h0_hit;
        o_res.hold_release_event = ev_hrel;
        o_res.count_event        = ev_cnt;
        o_res.reported_taps      = ev_cnt ? taps_out : '0;
        o_res.short_tap_event    = rel_hit && (r_mode == MODE_PUSHED);
        o_res.release_event      = rel_hit && (r_mode != MODE_IDLE);
        o_res.repeat_event       = rep_hit;
        o_res.pressed_mode       = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last         <= 1'b1;
            r_mode         <= MODE_IDLE;
            r_hold_pending <= 1'b0;
            r_taps         <= '0;
        end else if (i_adv) begin
            r_last         <= i_pin;
            r_mode         <= n_mode;
            r_hold_pending <= n_hold_pending;
            r_taps         <= n_taps;
        end
    end

endmodule
